>>> design/raid_stripe_writer_defines.svh
// Assertion macros for the RAID stripe writer.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef RAID_STRIPE_WRITER_DEFINES_SVH
`define RAID_STRIPE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define RSW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("raid_stripe_writer: same-cycle check failed");
`define RSW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("raid_stripe_writer: next-cycle check failed");
`else
`define RSW_ASSERT_NOW(lbl, ante, cons)
`define RSW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/rsw_pkg.sv
// Shared types and constants of the RAID stripe writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rsw_pkg;

	localparam int MAX_DISKS   = 8;
	localparam int BLOCK_BYTES = 4;
	localparam int STRIPE_BITS = 24;
	localparam int WORD_BITS   = 8 * BLOCK_BYTES;
	localparam int DISK_BITS   = 3;
	localparam int VB_BITS     = 3;
	localparam int NCFG_BITS   = 4;
	localparam int CNT_BITS    = $clog2(MAX_DISKS + 1);
	localparam int CFG_BITS    = 4;
	localparam int CFG_IDX_BITS = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_RAID_MODE  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DISK_COUNT = 1'd1;

	// RAID mode codes.
	localparam logic [1:0] MODE_STRIPE = 2'd0;
	localparam logic [1:0] MODE_MIRROR = 2'd1;
	localparam logic [1:0] MODE_PARITY = 2'd2;

	typedef struct packed {
		logic [WORD_BITS-1:0]   block_word;
		logic                   first_block;
		logic [STRIPE_BITS-1:0] start_stripe;
		logic                   final_block;
		logic [VB_BITS-1:0]     valid_bytes;
	} rsw_in_t;

	typedef struct packed {
		logic [DISK_BITS-1:0]   disk_index;
		logic [STRIPE_BITS-1:0] stripe_index;
		logic [WORD_BITS-1:0]   write_word;
		logic                   is_parity;
		logic                   run_last;
		logic                   chunk_done;
	} rsw_out_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_DATA,
		EMIT_PAD,
		EMIT_PAR,
		EMIT_MIRR
	} rsw_emit_t;

	typedef struct packed {
		logic      load;
		logic      prep;
		logic      mod_go;
		rsw_emit_t emit;
		logic      close;
	} rsw_cmd_t;

	typedef struct packed {
		logic skip;
		logic mirror;
		logic need_res;
		logic res_ok;
		logic more_pad;
		logic par_need;
		logic mirr_last;
		logic out_free;
		logic mod_busy;
	} rsw_stat_t;

endpackage

>>> design/rsw_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on rsw_pkg for the stripe and counter widths.
`timescale 1ns / 1ps

module rsw_mod import rsw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [STRIPE_BITS:0]  dividend,
	input  logic [CNT_BITS-1:0]   divisor,
	output logic                  busy,
	output logic                  done,
	output logic [CNT_BITS-1:0]   rem
);

	localparam int NBITS  = STRIPE_BITS + 1;
	localparam int CW     = $clog2(NBITS + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [NBITS-1:0] sh_q;
	logic [CNT_BITS-1:0] rem_q;
	logic [CNT_BITS:0]   trial;
	logic [CNT_BITS-1:0] rem_nx;

	always_comb begin
		trial = {rem_q, sh_q[NBITS-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_nx = CNT_BITS'(trial - {1'b0, divisor});
		end else begin
			rem_nx = CNT_BITS'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NBITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NBITS-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> design/rsw_datapath.sv
// Datapath of the stripe writer: configuration, stripe state, XOR parity and
// the output register. Depends on rsw_pkg and instantiates rsw_mod.
`timescale 1ns / 1ps

module rsw_datapath import rsw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  rsw_in_t                 blk,
	input  rsw_cmd_t                cmd,
	output rsw_stat_t               stat,
	output rsw_out_t                wr,
	output logic                    wr_valid,
	input  logic                    wr_ready
);

	logic [1:0]             mode_q;
	logic [NCFG_BITS-1:0]   ncfg_q;

	logic [WORD_BITS-1:0]   word_q;
	logic                   first_q;
	logic [STRIPE_BITS-1:0] start_q;
	logic                   fin_q;

	logic [STRIPE_BITS-1:0] stripe_q, stripe_d;
	logic [CNT_BITS-1:0]    slot_q, slot_d;
	logic [WORD_BITS-1:0]   acc_q, acc_d;
	logic                   active_q, active_d;
	logic [CNT_BITS-1:0]    res_q, res_d;
	logic                   res_ok_q, res_ok_d;

	rsw_out_t               wr_q, wr_d;
	logic                   wr_valid_q;

	logic [CNT_BITS-1:0]    n_eff, slots, pdisk, slot_nx, data_disk;
	logic                   is_mirr, is_par, more_pad, par_need, mirr_last, run_last;
	logic [WORD_BITS-1:0]   word_masked;
	logic                   mod_busy, mod_done;
	logic [CNT_BITS-1:0]    mod_rem;

	// Residue (stripe+1) mod n after one stripe step; the top stripe wraps to 0,
	// whose successor 1 is below every allowed n.
	function automatic logic [CNT_BITS-1:0] res_step(
		input logic [STRIPE_BITS-1:0] s,
		input logic [CNT_BITS-1:0]    r,
		input logic [CNT_BITS-1:0]    n
	);
		logic [CNT_BITS-1:0] r1;
		r1 = r + CNT_BITS'(1);
		if (&s) begin
			return CNT_BITS'(1);
		end else if (r1 == n) begin
			return '0;
		end else begin
			return r1;
		end
	endfunction

	always_comb begin
		if (ncfg_q < NCFG_BITS'(2)) begin
			n_eff = CNT_BITS'(2);
		end else if (ncfg_q > NCFG_BITS'(MAX_DISKS)) begin
			n_eff = CNT_BITS'(MAX_DISKS);
		end else begin
			n_eff = CNT_BITS'(ncfg_q);
		end
	end

	assign is_mirr   = (mode_q == MODE_MIRROR);
	assign is_par    = (mode_q == MODE_PARITY);
	assign slots     = is_mirr ? CNT_BITS'(1) : (is_par ? n_eff - CNT_BITS'(1) : n_eff);
	assign pdisk     = (res_q == '0) ? '0 : n_eff - res_q;
	assign slot_nx   = slot_q + CNT_BITS'(1);
	assign more_pad  = fin_q && (slot_nx < slots);
	assign par_need  = is_par && (fin_q || (slot_nx >= slots));
	assign data_disk = (is_par && (slot_q >= pdisk)) ? slot_nx : slot_q;
	assign mirr_last = (slot_nx == n_eff);

	always_comb begin
		for (int b = 0; b < BLOCK_BYTES; b++) begin
			word_masked[8*b +: 8] = (VB_BITS'(b) < blk.valid_bytes) ?
				blk.block_word[8*b +: 8] : 8'd0;
		end
	end

	rsw_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_go),
		.dividend ({1'b0, stripe_q} + (STRIPE_BITS + 1)'(1)),
		.divisor  (n_eff),
		.busy     (mod_busy),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		stripe_d = stripe_q;
		slot_d   = slot_q;
		acc_d    = acc_q;
		active_d = active_q;
		res_d    = res_q;
		res_ok_d = res_ok_q;

		if (cmd.prep) begin
			if (first_q) begin
				stripe_d = start_q;
				slot_d   = '0;
				acc_d    = '0;
				res_ok_d = 1'b0;
			end else if (!active_q) begin
				slot_d = '0;
				acc_d  = '0;
			end
			active_d = 1'b1;
			// A slot left over from a wider configuration closes the stripe unwritten.
			if (slot_d >= slots) begin
				slot_d   = '0;
				acc_d    = '0;
				res_d    = res_step(stripe_d, res_d, n_eff);
				stripe_d = stripe_d + STRIPE_BITS'(1);
			end
		end

		if (mod_done) begin
			res_d    = mod_rem;
			res_ok_d = 1'b1;
		end

		case (cmd.emit) inside
			EMIT_DATA: begin
				slot_d = slot_nx;
				acc_d  = acc_q ^ word_q;
			end
			EMIT_PAD, EMIT_MIRR: begin
				slot_d = slot_nx;
			end
			default: begin
			end
		endcase

		if (cmd.close) begin
			if (slot_q >= slots) begin
				slot_d   = '0;
				acc_d    = '0;
				res_d    = res_step(stripe_q, res_q, n_eff);
				stripe_d = stripe_q + STRIPE_BITS'(1);
			end
			if (fin_q) begin
				active_d = 1'b0;
			end
		end

		if (cfg_we) begin
			res_ok_d = 1'b0;
		end
	end

	always_comb begin
		unique case (cmd.emit)
			EMIT_PAR:  run_last = 1'b1;
			EMIT_MIRR: run_last = mirr_last;
			default:   run_last = !more_pad && !par_need;
		endcase
		wr_d.stripe_index = stripe_q;
		wr_d.run_last     = run_last;
		wr_d.chunk_done   = run_last && fin_q;
		unique case (cmd.emit)
			EMIT_PAR: begin
				wr_d.disk_index = DISK_BITS'(pdisk);
				wr_d.write_word = acc_q;
				wr_d.is_parity  = 1'b1;
			end
			EMIT_MIRR: begin
				wr_d.disk_index = DISK_BITS'(slot_q);
				wr_d.write_word = word_q;
				wr_d.is_parity  = 1'b0;
			end
			EMIT_PAD: begin
				wr_d.disk_index = DISK_BITS'(data_disk);
				wr_d.write_word = '0;
				wr_d.is_parity  = 1'b0;
			end
			default: begin
				wr_d.disk_index = DISK_BITS'(data_disk);
				wr_d.write_word = word_q;
				wr_d.is_parity  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_STRIPE;
			ncfg_q     <= NCFG_BITS'(3);
			stripe_q   <= '0;
			slot_q     <= '0;
			acc_q      <= '0;
			active_q   <= 1'b0;
			res_q      <= '0;
			res_ok_q   <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RAID_MODE:  mode_q <= cfg_data[1:0];
					REG_DISK_COUNT: ncfg_q <= cfg_data[NCFG_BITS-1:0];
					default: begin
					end
				endcase
			end
			stripe_q <= stripe_d;
			slot_q   <= slot_d;
			acc_q    <= acc_d;
			active_q <= active_d;
			res_q    <= res_d;
			res_ok_q <= res_ok_d;
			if (cmd.emit != EMIT_NONE) begin
				wr_valid_q <= 1'b1;
			end else if (wr_ready) begin
				wr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q  <= word_masked;
			first_q <= blk.first_block;
			start_q <= blk.start_stripe;
			fin_q   <= blk.final_block;
		end
		if (cmd.emit != EMIT_NONE) begin
			wr_q <= wr_d;
		end
	end

	assign stat.skip      = (mode_q > MODE_PARITY);
	assign stat.mirror    = is_mirr;
	assign stat.need_res  = is_par && !res_ok_q;
	assign stat.res_ok    = res_ok_q;
	assign stat.more_pad  = more_pad;
	assign stat.par_need  = par_need;
	assign stat.mirr_last = mirr_last;
	assign stat.out_free  = !wr_valid_q || wr_ready;
	assign stat.mod_busy  = mod_busy;

	assign wr       = wr_q;
	assign wr_valid = wr_valid_q;

endmodule

>>> design/rsw_controller.sv
// Sequencer of the stripe writer: steps one input word through its writes.
// Depends on rsw_pkg for the command and status structs.
`timescale 1ns / 1ps

module rsw_controller import rsw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      block_valid,
	output logic      block_ready,
	input  rsw_stat_t stat,
	output rsw_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_RES,
		S_MODW,
		S_DATA,
		S_PAD,
		S_PAR,
		S_MIRR,
		S_CLOSE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		block_ready = 1'b0;
		cmd         = '{load: 1'b0, prep: 1'b0, mod_go: 1'b0, emit: EMIT_NONE, close: 1'b0};
		unique case (state_q) inside
			S_IDLE: begin
				block_ready = 1'b1;
				// A word taken in the undefined mode is dropped without effect.
				if (block_valid && !stat.skip) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_RES;
			end
			S_RES: begin
				if (stat.mirror) begin
					state_d = S_MIRR;
				end else if (stat.need_res) begin
					cmd.mod_go = 1'b1;
					state_d    = S_MODW;
				end else begin
					state_d = S_DATA;
				end
			end
			S_MODW: begin
				if (stat.res_ok) begin
					state_d = S_DATA;
				end
			end
			S_DATA, S_PAD: begin
				if (stat.out_free) begin
					cmd.emit = (state_q == S_DATA) ? EMIT_DATA : EMIT_PAD;
					if (stat.more_pad) begin
						state_d = S_PAD;
					end else if (stat.par_need) begin
						state_d = S_PAR;
					end else begin
						state_d = S_CLOSE;
					end
				end
			end
			S_PAR: begin
				if (stat.out_free) begin
					cmd.emit = EMIT_PAR;
					state_d  = S_CLOSE;
				end
			end
			S_MIRR: begin
				if (stat.out_free) begin
					cmd.emit = EMIT_MIRR;
					if (stat.mirr_last) begin
						state_d = S_CLOSE;
					end
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/raid_stripe_writer.sv
// RAID stripe writer: turns a chunk of data words into block writes for the disks.
// Channels: block_valid/block_ready/block_data carry one data word of a chunk;
// write_valid/write_ready/write_data carry one block write (disk, stripe, contents).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), written while idle.
// The user is bound to it; the block does not enforce it. A word is taken only while
// the sequencer is idle. It then settles the stripe state, chooses the path, makes
// each block write in turn (one to n writes: the data word, padding and parity, or
// one copy per disk when mirroring) and closes the stripe. In parity mode the parity
// disk needs (stripe+1) mod n; it is tracked incrementally and recomputed by the
// bit-serial remainder unit after a new start stripe or a configuration write, and
// the word waits for that result before its first write.
// Writes leave through a single output register; a stalled receiver simply holds the
// sequencer in its current write state, and no write is lost or repeated.
// Reset returns the block to striping over three disks, stripe 0, no chunk active.
`timescale 1ns / 1ps
`include "raid_stripe_writer_defines.svh"

module raid_stripe_writer import rsw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    block_valid,
	output logic                    block_ready,
	input  rsw_in_t                 block_data,
	output logic                    write_valid,
	input  logic                    write_ready,
	output rsw_out_t                write_data
);

	rsw_cmd_t  cmd;
	rsw_stat_t stat;

	// Sequencer decides what happens each cycle; datapath owns all other state.
	rsw_controller u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.block_valid (block_valid),
		.block_ready (block_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	rsw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blk       (block_data),
		.cmd       (cmd),
		.stat      (stat),
		.wr        (write_data),
		.wr_valid  (write_valid),
		.wr_ready  (write_ready)
	);

	// A write is only produced when the output register can take it.
	`RSW_ASSERT_NOW(a_emit_room, cmd.emit != EMIT_NONE, !write_valid || write_ready)
	// The remainder unit must have finished before any write uses the parity disk.
	`RSW_ASSERT_NOW(a_mod_quiet, cmd.emit != EMIT_NONE, !stat.mod_busy)
	// Once a word is captured the input side closes until its writes are done.
	`RSW_ASSERT_NEXT(a_busy_after_load, cmd.load, !block_ready)
	// The parity block is always the last write caused by its word.
	`RSW_ASSERT_NOW(a_parity_last, write_valid && write_data.is_parity, write_data.run_last)

endmodule
